// File: sv/tmst_pkg.sv
// Shared constants, codes and entry type for the timed message slot table.
package tmst_pkg;

    localparam int SLOTS    = 16;
    localparam int SLOT_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    localparam int KIND_W   = 3;
    localparam int SLOTN_W  = 5;
    localparam int HOUR_W   = 7;
    localparam int MINUTE_W = 7;
    localparam int STATUS_W = 3;
    localparam int RSLOT_W  = 4;
    localparam int TAG_W    = HOUR_W + MINUTE_W;

    localparam logic [HOUR_W-1:0]   MAX_HOUR   = HOUR_W'(23);
    localparam logic [MINUTE_W-1:0] MAX_MINUTE = MINUTE_W'(59);

    localparam logic [KIND_W-1:0] KIND_ADD    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_CHANGE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_RETIME = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EXACT  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_LATEST = 3'd5;

    localparam logic [STATUS_W-1:0] STAT_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_BAD_TIME  = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_DUPLICATE = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_BAD_SLOT  = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd5;

    typedef struct packed {
        logic                valid;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

endpackage

// File: sv/tmst_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
module tmst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: sv/timed_message_slot_table_top.sv
// Top level of the timed message slot table: command sequencer around the slot memory.
//
// Each command transaction is answered by exactly one result transaction. The slots live in one
// RAM with a single read port, so every command reads all SLOTS entries in turn (one per cycle)
// to find duplicates, the first free slot, an exact match or the latest time at or before the
// query, and then writes back at most one entry. Commands are not overlapped: a new command is
// accepted only in the idle state, after the previous one has finished its scan and handed its
// result to the output register. A finished result is held in the output register, so the next
// command is accepted while it waits; the table starts empty after reset with no clearing pass.
module timed_message_slot_table_top
    import tmst_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // slot [4:0], hour [11:5], minute [18:12], zero fill
    input  logic [2:0]  s_axis_tuser,  // kind [2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // status [2:0], result_slot [6:3], result_hour [13:7],
                                       // result_minute [20:14], zero fill
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [SLOT_W:0]     issue_cnt_reg, issue_cnt_next;
    logic                rd_pend_reg, rd_pend_next;
    logic [SLOT_W-1:0]   rd_idx_reg, rd_idx_next;

    logic [KIND_W-1:0]   kind_reg, kind_next;
    logic [SLOTN_W-1:0]  slot_reg, slot_next;
    logic [HOUR_W-1:0]   hour_reg, hour_next;
    logic [MINUTE_W-1:0] minute_reg, minute_next;

    logic                dup_reg, dup_next;
    logic                free_found_reg, free_found_next;
    logic [SLOT_W-1:0]   free_idx_reg, free_idx_next;
    logic                find_found_reg, find_found_next;
    logic [SLOT_W-1:0]   find_idx_reg, find_idx_next;
    logic                best_found_reg, best_found_next;
    logic [SLOT_W-1:0]   best_idx_reg, best_idx_next;
    logic [TAG_W-1:0]    best_tag_reg, best_tag_next;
    logic                tgt_valid_reg, tgt_valid_next;
    logic [TAG_W-1:0]    tgt_tag_reg, tgt_tag_next;

    logic [SLOTS-1:0]    written_reg, written_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [RSLOT_W-1:0]  out_slot_reg, out_slot_next;
    logic [HOUR_W-1:0]   out_hour_reg, out_hour_next;
    logic [MINUTE_W-1:0] out_minute_reg, out_minute_next;

    logic                ram_we;
    logic [SLOT_W-1:0]   ram_waddr;
    entry_t              ram_wdata;
    logic                ram_re;
    logic [SLOT_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0]  ram_rdata;

    entry_t              rd_entry;
    logic                e_valid;
    logic [TAG_W-1:0]    e_tag;
    logic [TAG_W-1:0]    q_tag;
    logic                e_match;
    logic                e_before;

    logic                in_accept;
    logic                out_free;
    logic                time_ok;
    logic                slot_bad;
    logic [SLOT_W-1:0]   slot_idx;
    logic [STATUS_W-1:0] fin_status;
    logic [SLOT_W-1:0]   fin_idx;
    logic [TAG_W-1:0]    fin_tag;
    logic                fin_we;
    entry_t              fin_entry;

    tmst_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(SLOTS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_minute_reg, out_hour_reg, out_slot_reg, out_status_reg};

    // An entry never written since reset reads as an empty, zero-tagged slot.
    assign rd_entry = written_reg[rd_idx_reg] ? entry_t'(ram_rdata) : '0;
    assign e_valid  = rd_entry.valid;
    assign e_tag    = {rd_entry.hour, rd_entry.minute};
    assign q_tag    = {hour_reg, minute_reg};
    assign e_match  = e_valid && (e_tag == q_tag);
    assign e_before = e_valid && (e_tag <= q_tag);

    assign ram_re    = (state_reg == ST_SCAN) && (32'(issue_cnt_reg) < SLOTS);
    assign ram_raddr = issue_cnt_reg[SLOT_W-1:0];

    assign time_ok  = (hour_reg <= MAX_HOUR) && (minute_reg <= MAX_MINUTE);
    assign slot_bad = (32'(slot_reg) >= SLOTS);
    assign slot_idx = SLOT_W'(slot_reg);

    always_comb begin
        fin_status = STAT_OK;
        fin_idx    = '0;
        fin_tag    = '0;
        fin_we     = 1'b0;
        fin_entry  = '0;
        case (kind_reg)
            KIND_ADD: begin
                if (!time_ok) begin
                    fin_status = STAT_BAD_TIME;
                end else if (dup_reg) begin
                    fin_status = STAT_DUPLICATE;
                end else if (!free_found_reg) begin
                    fin_status = STAT_FULL;
                end else begin
                    fin_idx   = free_idx_reg;
                    fin_tag   = q_tag;
                    fin_we    = 1'b1;
                    fin_entry = '{valid: 1'b1, hour: hour_reg, minute: minute_reg};
                end
            end
            KIND_CHANGE: begin
                if (dup_reg) begin
                    fin_status = STAT_DUPLICATE;
                end else if (slot_bad) begin
                    fin_status = STAT_BAD_SLOT;
                end else begin
                    fin_idx   = slot_idx;
                    fin_tag   = q_tag;
                    fin_we    = 1'b1;
                    fin_entry = '{valid: 1'b1, hour: hour_reg, minute: minute_reg};
                end
            end
            KIND_REMOVE: begin
                if (slot_bad) begin
                    fin_status = STAT_BAD_SLOT;
                end else begin
                    fin_idx   = slot_idx;
                    fin_tag   = tgt_tag_reg;
                    fin_we    = 1'b1;
                    fin_entry = '{valid: 1'b0, hour: tgt_tag_reg[TAG_W-1:MINUTE_W],
                                  minute: tgt_tag_reg[MINUTE_W-1:0]};
                end
            end
            KIND_RETIME: begin
                if (slot_bad) begin
                    fin_status = STAT_BAD_SLOT;
                end else begin
                    fin_idx   = slot_idx;
                    fin_tag   = q_tag;
                    fin_we    = 1'b1;
                    fin_entry = '{valid: tgt_valid_reg, hour: hour_reg, minute: minute_reg};
                end
            end
            KIND_EXACT: begin
                if (!time_ok) begin
                    fin_status = STAT_BAD_TIME;
                end else if (!find_found_reg) begin
                    fin_status = STAT_NOT_FOUND;
                end else begin
                    fin_idx = find_idx_reg;
                    fin_tag = q_tag;
                end
            end
            KIND_LATEST: begin
                if (!time_ok) begin
                    fin_status = STAT_BAD_TIME;
                end else if (!best_found_reg) begin
                    fin_status = STAT_NOT_FOUND;
                end else begin
                    fin_idx = best_idx_reg;
                    fin_tag = best_tag_reg;
                end
            end
            default: begin
                fin_status = STAT_OK;
            end
        endcase
    end

    assign ram_we    = (state_reg == ST_DONE) && out_free && fin_we;
    assign ram_waddr = fin_idx;
    assign ram_wdata = fin_entry;

    always_comb begin
        state_next      = state_reg;
        issue_cnt_next  = issue_cnt_reg;
        rd_pend_next    = 1'b0;
        rd_idx_next     = rd_idx_reg;
        kind_next       = kind_reg;
        slot_next       = slot_reg;
        hour_next       = hour_reg;
        minute_next     = minute_reg;
        dup_next        = dup_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        find_found_next = find_found_reg;
        find_idx_next   = find_idx_reg;
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_tag_next   = best_tag_reg;
        tgt_valid_next  = tgt_valid_reg;
        tgt_tag_next    = tgt_tag_reg;
        written_next    = written_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_hour_next   = out_hour_reg;
        out_minute_next = out_minute_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    kind_next       = s_axis_tuser;
                    slot_next       = s_axis_tdata[4:0];
                    hour_next       = s_axis_tdata[11:5];
                    minute_next     = s_axis_tdata[18:12];
                    issue_cnt_next  = '0;
                    dup_next        = 1'b0;
                    free_found_next = 1'b0;
                    find_found_next = 1'b0;
                    best_found_next = 1'b0;
                    tgt_valid_next  = 1'b0;
                    tgt_tag_next    = '0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (ram_re) begin
                    issue_cnt_next = issue_cnt_reg + (SLOT_W + 1)'(1);
                    rd_pend_next   = 1'b1;
                    rd_idx_next    = ram_raddr;
                end
                if (rd_pend_reg) begin
                    if (e_match && ((kind_reg != KIND_CHANGE)
                                    || (32'(rd_idx_reg) != 32'(slot_reg)))) begin
                        dup_next = 1'b1;
                    end
                    if (!e_valid && !free_found_reg) begin
                        free_found_next = 1'b1;
                        free_idx_next   = rd_idx_reg;
                    end
                    if (e_match && !find_found_reg) begin
                        find_found_next = 1'b1;
                        find_idx_next   = rd_idx_reg;
                    end
                    if (e_before && (!best_found_reg || (e_tag > best_tag_reg))) begin
                        best_found_next = 1'b1;
                        best_idx_next   = rd_idx_reg;
                        best_tag_next   = e_tag;
                    end
                    if (32'(rd_idx_reg) == 32'(slot_reg)) begin
                        tgt_valid_next = e_valid;
                        tgt_tag_next   = e_tag;
                    end
                    if (32'(rd_idx_reg) == SLOTS - 1) begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_status_next = fin_status;
                    out_slot_next   = RSLOT_W'(fin_idx);
                    out_hour_next   = fin_tag[TAG_W-1:MINUTE_W];
                    out_minute_next = fin_tag[MINUTE_W-1:0];
                    if (fin_we) begin
                        written_next[fin_idx] = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            issue_cnt_reg <= '0;
            rd_pend_reg   <= 1'b0;
            written_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            issue_cnt_reg <= issue_cnt_next;
            rd_pend_reg   <= rd_pend_next;
            written_reg   <= written_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg      <= rd_idx_next;
        kind_reg        <= kind_next;
        slot_reg        <= slot_next;
        hour_reg        <= hour_next;
        minute_reg      <= minute_next;
        dup_reg         <= dup_next;
        free_found_reg  <= free_found_next;
        free_idx_reg    <= free_idx_next;
        find_found_reg  <= find_found_next;
        find_idx_reg    <= find_idx_next;
        best_found_reg  <= best_found_next;
        best_idx_reg    <= best_idx_next;
        best_tag_reg    <= best_tag_next;
        tgt_valid_reg   <= tgt_valid_next;
        tgt_tag_reg     <= tgt_tag_next;
        out_status_reg  <= out_status_next;
        out_slot_reg    <= out_slot_next;
        out_hour_reg    <= out_hour_next;
        out_minute_reg  <= out_minute_next;
    end

    // A failed command reports no slot and no time.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && (out_status_reg != STAT_OK))
            |-> (out_slot_reg == '0) && (out_hour_reg == '0) && (out_minute_reg == '0))
        else $error("failed command carries a slot or time");

    // A new result is only produced at the end of a command.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !$past(out_valid_reg && !m_axis_tready))
            |-> ($past(state_reg) == ST_DONE))
        else $error("result produced outside the completion step");

    // Read data only comes back while the table is being scanned.
    assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> (state_reg == ST_SCAN))
        else $error("slot read returned outside a scan");

    // The scan never runs past the last slot.
    assert property (@(posedge aclk) disable iff (!aresetn)
        32'(issue_cnt_reg) <= SLOTS)
        else $error("scan address ran past the table");

    // The slot memory is never written while it is being scanned.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN) |-> !ram_we)
        else $error("slot memory written during a scan");

endmodule
